@@ rtl/vfr_pkg.sv @@
package vfr_pkg;

  // Datapath widths inside the rotator and the gain stage.
  localparam int GUARD_BITS = 14;
  localparam int DATA_W     = 34;
  localparam int Z_W        = 33;
  localparam int PROD_W     = 66;
  localparam int ATAN_LEN   = 24;
  localparam int RES_LSB    = 45;

  // Inverse of the converged CORDIC gain in Q31.
  localparam logic signed [31:0] KINV_Q31 = 32'sd1304065748;
  // Half of one output LSB, added before the final shift.
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 66'sh1000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_ROT_GO,
    S_ROT,
    S_SCALE,
    S_EMIT
  } vfr_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_Y
  } vfr_gain_ph_e;

  typedef struct packed {
    logic busy;
    logic done;
  } vfr_stat_t;

  // atan(2^-i) in binary angle units, 2^32 per full turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679842;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/vfr_cordic_unit.sv @@
module vfr_cordic_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [15:0]                 base_x_i,
  input  logic signed [15:0]                 base_y_i,
  input  logic [31:0]                        ang_i,
  output logic signed [vfr_pkg::DATA_W-1:0]  x_o,
  output logic signed [vfr_pkg::DATA_W-1:0]  y_o,
  output vfr_pkg::vfr_stat_t                 stat_o
);
  import vfr_pkg::*;

  localparam int IW = $clog2(CORDIC_STAGES);

  logic signed [DATA_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]    z_q, z_d;
  logic [IW-1:0]            it_q;
  logic                     busy_q, done_q;

  logic                     flip;
  logic [31:0]              ang_sum;
  logic signed [DATA_W-1:0] x_ld, y_ld, dx, dy;
  logic signed [Z_W-1:0]    atan_z;

  always_comb begin
    ang_sum = ang_i + 32'h4000_0000;
    flip    = ang_sum[31];
    x_ld    = DATA_W'(base_x_i) <<< GUARD_BITS;
    y_ld    = DATA_W'(base_y_i) <<< GUARD_BITS;
    dx      = y_q >>> it_q;
    dy      = x_q >>> it_q;
    atan_z  = $signed(Z_W'(atan_turn(5'(it_q))));
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    if (start_i) begin
      // Pre-rotate by a half turn so the residual angle lies within a quarter turn.
      x_d = flip ? -x_ld : x_ld;
      y_d = flip ? -y_ld : y_ld;
      z_d = Z_W'($signed(ang_i ^ (flip ? 32'h8000_0000 : 32'h0)));
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_z;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q   <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        it_q   <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (it_q == IW'(CORDIC_STAGES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          it_q <= it_q + IW'(1);
        end
      end
    end
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/vfr_gain_unit.sv @@
module vfr_gain_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [vfr_pkg::DATA_W-1:0]  x_i,
  input  logic signed [vfr_pkg::DATA_W-1:0]  y_i,
  output logic signed [15:0]                 res_x_o,
  output logic signed [15:0]                 res_y_o,
  output vfr_pkg::vfr_stat_t                 stat_o
);
  import vfr_pkg::*;

  vfr_gain_ph_e             ph_q, ph_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, rnd;
  logic signed [DATA_W-1:0] y_hold_q, mul_a;
  logic signed [15:0]       rx_q, ry_q, res_sat;
  logic                     done_q;

  // One multiplier serves x and then y.
  always_comb begin
    mul_a   = (ph_q == PH_IDLE) ? x_i : y_hold_q;
    prod_d  = PROD_W'(mul_a) * PROD_W'(KINV_Q31);
    rnd     = prod_q + ROUND_HALF;
    res_sat = sat16($signed(rnd[PROD_W-1:RES_LSB]));
    ph_d    = ph_q;
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          ph_d = PH_X;
        end
      end
      PH_X:    ph_d = PH_Y;
      PH_Y:    ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((ph_q == PH_IDLE && start_i) || ph_q == PH_X) begin
      prod_q <= prod_d;
    end
    if (ph_q == PH_IDLE && start_i) begin
      y_hold_q <= y_i;
    end
    if (ph_q == PH_X) begin
      rx_q <= res_sat;
    end
    if (ph_q == PH_Y) begin
      ry_q <= res_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == PH_Y);
    end
  end

  assign res_x_o     = rx_q;
  assign res_y_o     = ry_q;
  assign stat_o.busy = (ph_q != PH_IDLE);
  assign stat_o.done = done_q;

endmodule

@@ rtl/vector_fan_rotation_core.sv @@
// Fan rotator: each accepted beat carries a centre vector, an angular step and a
// count n (saturated to MAX_WAYS); the block then emits n beats, the centre vector
// rotated by (2k - (n-1)) * step / 2 for k = 0 .. n-1, with way_index_o = k and
// last_o on the final one. A count of zero is accepted and emits nothing. Angles
// are binary, 65536 per full turn, positive counter-clockwise; results are
// gain-compensated and saturated to signed 16 bits. All vectors of a fan go
// through one shared CORDIC micro-rotation unit, one iteration per cycle, and one
// shared gain multiplier, one vector at a time, and an item stalls the input
// until the result of its last vector is loaded. The last result sits in an
// output register, so the next item can be accepted while it waits to be taken.
module vector_fan_rotation_core #(
  parameter int MAX_WAYS      = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] base_x_i,
  input  logic signed [15:0] base_y_i,
  input  logic signed [15:0] step_angle_i,
  input  logic [5:0]         way_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [4:0]         way_index_o,
  output logic               last_o
);
  import vfr_pkg::*;

  localparam int CW = $clog2(MAX_WAYS + 1);

  vfr_state_e         state_q, state_d;
  logic signed [15:0] bx_q, by_q, step_q;
  logic [CW-1:0]      n_q, k_q, n_sat;
  logic [31:0]        ang_q;
  logic [16:0]        mult;
  logic [16:0]        prod;

  logic               out_valid_q, out_last_q, out_free, out_load, in_acc, is_last;
  logic signed [15:0] out_x_q, out_y_q;
  logic [4:0]         out_idx_q;

  logic                     cordic_start;
  logic signed [DATA_W-1:0] rot_x, rot_y;
  logic signed [15:0]       res_x, res_y;
  vfr_stat_t                cordic_stat, gain_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign n_sat      = (8'(way_count_i) > 8'(MAX_WAYS)) ? CW'(MAX_WAYS) : CW'(way_count_i);
  assign is_last    = (CW'(k_q + CW'(1)) == n_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Only the low 17 bits of multiple times step survive the shift to 2^32 per turn.
  assign mult = (17'(k_q) << 1) - 17'(n_q) + 17'd1;
  assign prod = mult * {step_q[15], step_q};

  always_comb begin
    state_d      = state_q;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && n_sat != '0) begin
          state_d = S_ANGLE;
        end
      end
      S_ANGLE: state_d = S_ROT_GO;
      S_ROT_GO: begin
        cordic_start = 1'b1;
        state_d      = S_ROT;
      end
      S_ROT: begin
        if (cordic_stat.done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        if (gain_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = is_last ? S_IDLE : S_ANGLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        n_q <= n_sat;
        k_q <= '0;
      end else if (out_load) begin
        k_q <= CW'(k_q + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bx_q   <= base_x_i;
      by_q   <= base_y_i;
      step_q <= step_angle_i;
    end
    if (state_q == S_ANGLE) begin
      ang_q <= {prod, 15'b0};
    end
    if (out_load) begin
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_idx_q  <= 5'(k_q);
      out_last_q <= is_last;
    end
  end

  vfr_cordic_unit #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .base_x_i(bx_q),
    .base_y_i(by_q),
    .ang_i   (ang_q),
    .x_o     (rot_x),
    .y_o     (rot_y),
    .stat_o  (cordic_stat)
  );

  vfr_gain_unit u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_stat.done),
    .x_i    (rot_x),
    .y_i    (rot_y),
    .res_x_o(res_x),
    .res_y_o(res_y),
    .stat_o (gain_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign way_index_o = out_idx_q;
  assign last_o      = out_last_q;

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !cordic_stat.busy && !gain_stat.busy)
    else $error("shared units busy while the sequencer is idle");

  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> k_q < n_q)
    else $error("way counter ran past the fan size");

  a_gain_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_stat.done |-> state_q == S_SCALE)
    else $error("gain result arrived outside the scale step");

  a_fan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && n_sat != '0 |=> state_q == S_ANGLE && k_q == '0)
    else $error("accepted fan did not start at its first way");

endmodule
